// ----- design/weighted_random_trigger_router_core_assert.svh -----
// Assertion macros for the weighted random trigger router.
`ifndef WEIGHTED_RANDOM_TRIGGER_ROUTER_CORE_ASSERT_SVH
`define WEIGHTED_RANDOM_TRIGGER_ROUTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define WRTR_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wrtr: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define WRTR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wrtr: next-cycle check failed");

`endif

// ----- design/wrtr_pkg.sv -----
// Types, constants and helpers for the weighted random trigger router.
package wrtr_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int GEN_W       = 32;
	localparam int LIMIT_W     = 16;
	localparam int COUNT_W     = 3;
	localparam int MAX_OUTLETS = 6;
	localparam int OUTLET_W    = 3;
	localparam int V_W         = 31;
	localparam int SCALED_W    = V_W + LIMIT_W;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	localparam logic [GEN_W-1:0] SEED_MULT = 32'd1319;
	localparam logic [GEN_W-1:0] LCG_MULT  = 32'd435898247;
	localparam logic [GEN_W-1:0] LCG_ADD   = 32'd382842987;
	localparam logic [GEN_W-1:0] GEN_RESET = 32'd309436081;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;

	typedef logic [LIMIT_W-1:0] limit_t;

	localparam limit_t LIMIT_RESET [MAX_OUTLETS] = '{
		16'd50, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0
	};

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SEED,
		REG_OUTLET_COUNT,
		REG_LIMIT_0,
		REG_LIMIT_1,
		REG_LIMIT_2,
		REG_LIMIT_3,
		REG_LIMIT_4,
		REG_LIMIT_5
	} cfg_reg_t;

	// Clamp the outlet count into 1 .. MAX_OUTLETS.
	function automatic logic [COUNT_W-1:0] outlets_in_use(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] n;
		n = count;
		if (count == '0) begin
			n = COUNT_W'(1);
		end else if (count > COUNT_W'(MAX_OUTLETS)) begin
			n = COUNT_W'(MAX_OUTLETS);
		end
		return n;
	endfunction

endpackage

// ----- design/weighted_random_trigger_router_core.sv -----
// Weighted random trigger router: trigger detect, LCG draw and weighted outlet pick.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | sample
//   out     | output    | out_valid / out_stall| hit, outlet, value
//   cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One item is accepted per cycle unless stalled; it moves via stage one to the result register.
// The generator step is one 32-bit multiply-add fed back into the generator
// register, and it sets the cycle time of the input stage.
// The outlet pick is one 31x16 multiply and six 16-bit compares before the result register.
// Reset loads all but the payload registers at once; there is no clearing pass.
// A stall on the output holds a full result register and, once stage one is full, stalls the input.
`include "weighted_random_trigger_router_core_assert.svh"

module weighted_random_trigger_router_core
	import wrtr_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [SAMPLE_W-1:0]   sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic        [OUTLET_W-1:0]   outlet,
	output logic signed [SAMPLE_W-1:0]   value,
	input  logic                         cfg_we,
	input  logic        [CFG_INDEX_W-1:0] cfg_index,
	input  logic        [CFG_DATA_W-1:0] cfg_data
);

	logic [GEN_W-1:0]    gen_q;
	logic                prev_zero_q;
	logic [COUNT_W-1:0]  count_q;
	limit_t              limit_q [MAX_OUTLETS];

	logic                valid_s1;
	logic                trig_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [V_W-1:0]      v_s1;

	logic                valid_s2;
	logic                hit_s2;
	logic [OUTLET_W-1:0] outlet_s2;
	logic [SAMPLE_W-1:0] value_s2;

	logic                s1_load;
	logic                s2_load;
	logic                in_acc;
	logic                trig;
	logic [COUNT_W-1:0]  n_use;
	limit_t              range;
	logic [SCALED_W-1:0] scaled;
	limit_t              scaled_hi;
	logic                pick_hit;
	logic [OUTLET_W-1:0] pick_idx;

	// Handshake: each stage loads when the stage after it is empty or moving.
	assign s2_load  = !valid_s2 || !out_stall;
	assign s1_load  = !valid_s1 || s2_load;
	assign in_stall = !s1_load;
	assign in_acc   = in_valid && s1_load;

	// A trigger is a nonzero sample following a zero sample.
	assign trig = (sample != '0) && prev_zero_q;

	// Configuration registers and the generator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= GEN_RESET;
			prev_zero_q <= 1'b1;
			count_q     <= COUNT_RESET;
			for (int i = 0; i < MAX_OUTLETS; i++) begin
				limit_q[i] <= LIMIT_RESET[i];
			end
		end else begin
			if (in_acc) begin
				prev_zero_q <= (sample == '0);
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SEED: begin
						gen_q <= GEN_W'(cfg_data * SEED_MULT);
					end
					REG_OUTLET_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					REG_LIMIT_0:      limit_q[0] <= cfg_data[LIMIT_W-1:0];
					REG_LIMIT_1:      limit_q[1] <= cfg_data[LIMIT_W-1:0];
					REG_LIMIT_2:      limit_q[2] <= cfg_data[LIMIT_W-1:0];
					REG_LIMIT_3:      limit_q[3] <= cfg_data[LIMIT_W-1:0];
					REG_LIMIT_4:      limit_q[4] <= cfg_data[LIMIT_W-1:0];
					REG_LIMIT_5:      limit_q[5] <= cfg_data[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end else if (in_acc && trig) begin
				gen_q <= GEN_W'(gen_q * LCG_MULT + LCG_ADD);
			end
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage one payload: the sample, its trigger flag and the drawn value.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample;
			trig_s1   <= trig;
			v_s1      <= gen_q[V_W-1:0];
		end
	end

	// Scale the draw by the range; only the bits at and above 2^31 matter.
	assign n_use     = outlets_in_use(count_q);
	assign range     = limit_q[COUNT_W'(n_use - COUNT_W'(1))];
	assign scaled    = SCALED_W'(v_s1) * SCALED_W'(range);
	assign scaled_hi = scaled[SCALED_W-1:V_W];

	// Pick the first outlet in use whose limit exceeds the scaled draw.
	always_comb begin
		pick_hit = 1'b0;
		pick_idx = '0;
		for (int k = MAX_OUTLETS - 1; k >= 0; k--) begin
			if ((OUTLET_W'(k) < n_use) && (scaled_hi < limit_q[k])) begin
				pick_hit = 1'b1;
				pick_idx = OUTLET_W'(k);
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload; every field is zero unless an outlet was picked.
	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			hit_s2    <= trig_s1 && pick_hit;
			outlet_s2 <= (trig_s1 && pick_hit) ? pick_idx : '0;
			value_s2  <= (trig_s1 && pick_hit) ? sample_s1 : '0;
		end
	end

	assign out_valid = valid_s2;
	assign hit       = hit_s2;
	assign outlet    = outlet_s2;
	assign value     = signed'(value_s2);

	// A result without a hit carries zero on every field.
	`WRTR_ASSERT_IMPL(a_miss_is_zero, out_valid && !hit, outlet == '0 && value == '0)
	// A routed sample is never zero, since only nonzero samples trigger.
	`WRTR_ASSERT_IMPL(a_hit_nonzero, out_valid && hit, value != '0)
	// The picked outlet is always one of the outlets in use.
	`WRTR_ASSERT_IMPL(a_outlet_in_use, out_valid && hit, outlet < n_use)
	// After a trigger the next sample cannot trigger again.
	`WRTR_ASSERT_NEXT(a_no_double_trig, in_acc && trig, !prev_zero_q)

endmodule

// ----- dv/weighted_random_trigger_router_checker.sv -----
`timescale 1ns / 1ps
// Checker for the weighted random trigger router: predicts each routed sample and compares.
module weighted_random_trigger_router_checker
	import wrtr_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [SAMPLE_W-1:0]    sample,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          hit,
	input  logic        [OUTLET_W-1:0]    outlet,
	input  logic signed [SAMPLE_W-1:0]    value,
	input  logic                          cfg_we,
	input  logic        [CFG_INDEX_W-1:0] cfg_index,
	input  logic        [CFG_DATA_W-1:0]  cfg_data,
	output int                            pending,
	output int                            errors,
	output int                            checked,
	output int                            hits
);

	// One routing decision as the block reports it.
	typedef struct packed {
		logic                hit;
		logic [OUTLET_W-1:0] outlet;
		logic [SAMPLE_W-1:0] value;
	} route_t;

	// Private copy of the generator, trigger history and weight registers.
	logic [GEN_W-1:0]   lcg;
	logic               prev_zero;
	logic [COUNT_W-1:0] count_reg;
	limit_t             limits [MAX_OUTLETS];

	route_t routes_due [$];
	route_t due;

	initial begin
		pending = 0;
		errors  = 0;
		checked = 0;
		hits    = 0;
	end

	// Work out where a sample goes and advance the generator on a trigger.
	function automatic route_t route_sample(input logic signed [SAMPLE_W-1:0] s);
		route_t              r;
		int                  n;
		int                  k;
		logic                found;
		logic [V_W-1:0]      draw;
		logic [SCALED_W-1:0] scaled;
		r = '0;
		if (s != '0 && prev_zero) begin
			n = int'(count_reg);
			if (n < 1) begin
				n = 1;
			end else if (n > MAX_OUTLETS) begin
				n = MAX_OUTLETS;
			end
			draw   = lcg[V_W-1:0];
			scaled = SCALED_W'(draw) * SCALED_W'(limits[n-1]);
			found  = 1'b0;
			for (k = 0; k < n; k++) begin
				if (!found && scaled < {limits[k], {V_W{1'b0}}}) begin
					found    = 1'b1;
					r.hit    = 1'b1;
					r.outlet = OUTLET_W'(k);
					r.value  = s;
				end
			end
			lcg = lcg * LCG_MULT + LCG_ADD;
		end
		prev_zero = (s == '0);
		return r;
	endfunction

	// Watch the channels: check results first, then queue new predictions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg       = GEN_RESET;
			prev_zero = 1'b1;
			count_reg = COUNT_RESET;
			for (int i = 0; i < MAX_OUTLETS; i++) begin
				limits[i] = LIMIT_RESET[i];
			end
			routes_due.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (routes_due.size() == 0) begin
					$error("result with no item pending: hit %0d outlet %0d value %0d",
						hit, outlet, value);
					errors++;
				end else begin
					due = routes_due.pop_front();
					checked++;
					if (due.hit) begin
						hits++;
					end
					if (hit !== due.hit) begin
						$error("hit: expected %0d, actual %0d", due.hit, hit);
						errors++;
					end
					if (outlet !== due.outlet) begin
						$error("outlet: expected %0d, actual %0d", due.outlet, outlet);
						errors++;
					end
					if (value !== due.value) begin
						$error("value: expected %0d, actual %0d",
							$signed(due.value), value);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				routes_due.push_back(route_sample(sample));
			end
			// Register writes land at the same edge as in the block.
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SEED: begin
						lcg = cfg_data * SEED_MULT;
					end
					REG_OUTLET_COUNT: begin
						count_reg = cfg_data[COUNT_W-1:0];
					end
					default: begin
						limits[int'(cfg_index) - int'(REG_LIMIT_0)] = cfg_data[LIMIT_W-1:0];
					end
				endcase
			end
			pending <= routes_due.size();
		end
	end

endmodule

// ----- dv/weighted_random_trigger_router_core_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the weighted random trigger router: stimulus, settings and verdict.
module weighted_random_trigger_router_core_test;
	import wrtr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 125;
	localparam int QUIET_PHASE    = 4;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic signed [SAMPLE_W-1:0]   sample    = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic                         hit;
	logic        [OUTLET_W-1:0]   outlet;
	logic signed [SAMPLE_W-1:0]   value;
	logic                         cfg_we    = 1'b0;
	cfg_reg_t                     cfg_index = REG_SEED;
	logic        [CFG_DATA_W-1:0] cfg_data  = '0;

	int pending;
	int errors;
	int checked;
	int hits;
	int idle_pct      = 38;
	int items_sent    = 0;
	int settings_used = 0;
	int quiet_cycles  = 0;

	// Weight limits for the next setting.
	limit_t plan [MAX_OUTLETS];

	always #10 clk = ~clk;

	weighted_random_trigger_router_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.outlet    (outlet),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	weighted_random_trigger_router_checker route_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.outlet    (outlet),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors),
		.checked   (checked),
		.hits      (hits)
	);

	// The result side stalls at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	// End the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL weighted_random_trigger_router_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample, with a random gap first, and wait until it is taken.
	task automatic put_sample(input logic signed [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Let every routed sample come out before touching the registers.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Write the seed, the outlet count and all six limits from plan.
	task automatic load_setting(input logic [CFG_DATA_W-1:0] seed_val,
			input logic [COUNT_W-1:0] count);
		settle();
		write_reg(REG_SEED, seed_val);
		write_reg(REG_OUTLET_COUNT, CFG_DATA_W'(count));
		for (int k = 0; k < MAX_OUTLETS; k++) begin
			write_reg(cfg_reg_t'(int'(REG_LIMIT_0) + k), CFG_DATA_W'(plan[k]));
		end
		settings_used++;
	endtask

	// Mostly zero-then-nonzero patterns so that triggers are frequent.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int                         roll;
		logic signed [SAMPLE_W-1:0] s;
		roll = $urandom_range(99);
		if (roll < 45) begin
			s = '0;
		end else if (roll < 55) begin
			case ($urandom_range(3))
				0:       s = 24'sh7fffff;
				1:       s = 24'sh800000;
				2:       s = 24'sh000001;
				default: s = 24'shffffff;
			endcase
		end else begin
			s = SAMPLE_W'($urandom);
		end
		return s;
	endfunction

	initial begin
		int acc;
		int step_cap;
		int mode;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first sample triggers, back-to-back nonzero samples do not.
		put_sample(24'sh7fffff);
		put_sample(24'sh800000);
		put_sample(24'sh000000);
		put_sample(24'sh800000);
		put_sample(24'sh000000);
		put_sample(24'sh000000);
		put_sample(24'sh000001);
		put_sample(24'shffffff);

		// Outlet count of zero acts as one; lowest seed.
		plan = '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		load_setting(32'h8000_0000, 3'd0);
		put_sample(24'sh000000);
		put_sample(24'sh000005);
		put_sample(24'sh000000);
		put_sample(-24'sd5);

		// Outlet count above six saturates; highest seed.
		plan = '{16'd100, 16'd200, 16'd300, 16'd400, 16'd500, 16'd65535};
		load_setting(32'h7fff_ffff, 3'd7);
		put_sample(24'sh000000);
		put_sample(24'sh555555);
		put_sample(24'sh000000);
		put_sample(24'shaaaaaa);
		put_sample(24'sh000000);
		put_sample(24'sh000003);

		// A range of zero: triggers pick no outlet but still step the generator.
		plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		load_setting(32'h0000_0000, 3'd6);
		put_sample(24'sh000000);
		put_sample(24'sh000007);
		put_sample(24'sh000000);
		put_sample(24'sh000009);

		// Limits that are not ascending.
		plan = '{16'd40, 16'd60, 16'd20, 16'd0, 16'd0, 16'd0};
		load_setting(32'd12345, 3'd3);
		put_sample(24'sh000000);
		put_sample(24'sh00000b);
		put_sample(24'sh000000);
		put_sample(24'sh00000c);

		// Random settings, each with a burst of random samples.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			mode = $urandom_range(99);
			step_cap = (mode < 50) ? 10000 : 30000;
			acc = 0;
			for (int k = 0; k < MAX_OUTLETS; k++) begin
				if (mode < 75) begin
					acc = acc + $urandom_range(step_cap);
					if (acc > 65535) begin
						acc = 65535;
					end
					plan[k] = limit_t'(acc);
				end else if (mode < 92) begin
					plan[k] = limit_t'($urandom);
				end else begin
					plan[k] = '0;
				end
			end
			load_setting($urandom, COUNT_W'($urandom_range(7)));
			idle_pct = (p == QUIET_PHASE) ? 0 : 38;
			repeat (PHASE_ITEMS) put_sample(pick_sample());
		end

		settle();
		$display("Routed %0d samples over %0d weight settings plus the reset one.",
			items_sent, settings_used);
		$display("Checked %0d results, %0d of them sent to an outlet.", checked, hits);
		if (errors == 0 && pending == 0) begin
			$display("PASS weighted_random_trigger_router_core");
		end else begin
			$display("FAIL weighted_random_trigger_router_core");
		end
		$finish;
	end

endmodule

// ----- weighted_random_trigger_router_core.f -----
+incdir+design
design/wrtr_pkg.sv
design/weighted_random_trigger_router_core.sv
dv/weighted_random_trigger_router_checker.sv
dv/weighted_random_trigger_router_core_test.sv
